>>> hw/rtl/llbr_pkg.sv
// Package for the box reorder block: command codes, field widths and
// the word types carried by the request, response and register channels.
// No dependencies.
package llbr_pkg;

   localparam int BOX_W = 17;
   localparam int CMD_W = 3;
   localparam int SUM_W = 32;

   localparam logic [CMD_W-1:0] CMD_START   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LEFT    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RIGHT   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SWAP    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd4;
   localparam logic [CMD_W-1:0] CMD_REPORT  = 3'd5;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [BOX_W-1:0] first_box;
      logic [BOX_W-1:0] second_box;
   } req_word_type;

   typedef struct packed {
      logic [SUM_W-1:0] odd_position_sum;
   } rsp_word_type;

   typedef logic [BOX_W-1:0] csr_word_type;

endpackage

>>> hw/rtl/llbr_chan_if.sv
// Valid/ready channel carrying one word of a given type.
// Used with the word types of llbr_pkg.
interface llbr_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/llbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module llbr_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 65538
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> hw/rtl/linked_list_box_reorder.sv
// Box reorder block: doubly linked list of boxes in two link RAMs, run by
// one sequencer. Depends on llbr_pkg, llbr_chan_if and llbr_ram.
//
//   port      dir  word
//   req_chan  in   command, first_box, second_box
//   rsp_chan  out  odd_position_sum (report only)
//   csr_chan  in   box_count
//
// Move runs S_M0 to S_M4; swap runs S_W0 to S_W3, where S_W3 rewrites the links of both boxes
// and their neighbours; reverse and bad moves end in S_IDLE. Start writes one link RAM entry
// per cycle, entries 0 to linked count + 1. Report takes one next_link read per hop, with one
// extra hop first when reversed with an even count, and goes straight to S_OUT with no list.
// Reset is synchronous; the link RAMs are not cleared and are filled by start.
// A report waits for the response register to drain before it ends.
module linked_list_box_reorder #(
   parameter int MAX_BOXES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   llbr_chan_if.sink   req_chan,
   llbr_chan_if.source rsp_chan,
   llbr_chan_if.sink   csr_chan
);
   import llbr_pkg::*;

   localparam int DEPTH = MAX_BOXES + 2;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_START = 4'd1;
   localparam logic [3:0] S_M0    = 4'd2;
   localparam logic [3:0] S_M1    = 4'd3;
   localparam logic [3:0] S_M2    = 4'd4;
   localparam logic [3:0] S_M3    = 4'd5;
   localparam logic [3:0] S_M4    = 4'd6;
   localparam logic [3:0] S_W0    = 4'd7;
   localparam logic [3:0] S_W1    = 4'd8;
   localparam logic [3:0] S_W2    = 4'd9;
   localparam logic [3:0] S_W3    = 4'd10;
   localparam logic [3:0] S_R0    = 4'd11;
   localparam logic [3:0] S_R1    = 4'd12;
   localparam logic [3:0] S_OUT   = 4'd13;

   logic [3:0]       state_ff, state_in;
   logic [BOX_W-1:0] box_count_ff;
   logic             reversed_ff, reversed_in;
   logic [AW-1:0]    linked_ff, linked_in;
   logic [AW-1:0]    x_ff, x_in, y_ff, y_in;
   logic             left_ff, left_in;
   logic [AW-1:0]    tmp_ff, tmp_in;
   logic [AW-1:0]    xp_ff, xp_in, xn_ff, xn_in, yp_ff, yp_in, yn_ff, yn_in;
   logic [1:0]       step_ff, step_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic [AW-1:0]    remain_ff, remain_in;
   logic [1:0]       hops_ff, hops_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0] rsp_sum_ff, rsp_sum_in;

   logic          nx_we, pv_we;
   logic [AW-1:0] nx_waddr, nx_wdata, pv_waddr, pv_wdata;
   logic [AW-1:0] rd_addr, nx_rdata, pv_rdata;

   logic          ids_ok;
   logic [AW-1:0] clamp_n;
   logic [1:0]    hops_dec;

   llbr_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_next_ram (
      .clock(clock), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
      .raddr(rd_addr), .rdata(nx_rdata)
   );

   llbr_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_prev_ram (
      .clock(clock), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
      .raddr(rd_addr), .rdata(pv_rdata)
   );

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign csr_chan.ready   = 1'b1;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = '{odd_position_sum: rsp_sum_ff};

   assign ids_ok = (req_chan.payload.first_box != '0) &&
                   (req_chan.payload.second_box != '0) &&
                   (32'(req_chan.payload.first_box) <= 32'(linked_ff)) &&
                   (32'(req_chan.payload.second_box) <= 32'(linked_ff)) &&
                   (req_chan.payload.first_box != req_chan.payload.second_box);

   always_comb begin
      if (box_count_ff == '0) begin
         clamp_n = AW'(1);
      end else if (32'(box_count_ff) > 32'(MAX_BOXES)) begin
         clamp_n = AW'(MAX_BOXES);
      end else begin
         clamp_n = AW'(box_count_ff);
      end
   end

   assign hops_dec = hops_ff - 2'd1;

   always_comb begin
      state_in     = state_ff;
      reversed_in  = reversed_ff;
      linked_in    = linked_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      left_in      = left_ff;
      tmp_in       = tmp_ff;
      xp_in        = xp_ff;
      xn_in        = xn_ff;
      yp_in        = yp_ff;
      yn_in        = yn_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      remain_in    = remain_ff;
      hops_in      = hops_ff;
      sum_in       = sum_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      nx_we        = 1'b0;
      pv_we        = 1'b0;
      nx_waddr     = '0;
      nx_wdata     = '0;
      pv_waddr     = '0;
      pv_wdata     = '0;
      rd_addr      = x_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               x_in = AW'(req_chan.payload.first_box);
               y_in = AW'(req_chan.payload.second_box);
               unique case (req_chan.payload.command)
                  CMD_START: begin
                     linked_in   = clamp_n;
                     reversed_in = 1'b0;
                     idx_in      = '0;
                     state_in    = S_START;
                  end
                  CMD_LEFT, CMD_RIGHT: begin
                     left_in = (req_chan.payload.command == CMD_LEFT) != reversed_ff;
                     if (ids_ok) begin
                        state_in = S_M0;
                     end
                  end
                  CMD_SWAP: begin
                     if (ids_ok) begin
                        state_in = S_W0;
                     end
                  end
                  CMD_REVERSE: begin
                     reversed_in = !reversed_ff;
                  end
                  CMD_REPORT: begin
                     sum_in    = '0;
                     idx_in    = '0;
                     remain_in = AW'((32'(linked_ff) + 32'd1) >> 1);
                     hops_in   = (reversed_ff && !linked_ff[0]) ? 2'd2 : 2'd1;
                     state_in  = (linked_ff == '0) ? S_OUT : S_R0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_START: begin
            nx_we    = 1'b1;
            pv_we    = 1'b1;
            nx_waddr = idx_ff;
            pv_waddr = idx_ff;
            pv_wdata = (idx_ff == '0) ? '0 : idx_ff - AW'(1);
            if (idx_ff == linked_ff + AW'(1)) begin
               nx_wdata = idx_ff;
               state_in = S_IDLE;
            end else begin
               nx_wdata = idx_ff + AW'(1);
               idx_in   = idx_ff + AW'(1);
            end
         end
         S_M0: begin
            rd_addr  = x_ff;
            state_in = S_M1;
         end
         S_M1: begin
            nx_we    = 1'b1;
            nx_waddr = pv_rdata;
            nx_wdata = nx_rdata;
            pv_we    = 1'b1;
            pv_waddr = nx_rdata;
            pv_wdata = pv_rdata;
            state_in = S_M2;
         end
         S_M2: begin
            rd_addr  = y_ff;
            state_in = S_M3;
         end
         S_M3: begin
            nx_we    = 1'b1;
            pv_we    = 1'b1;
            nx_waddr = x_ff;
            pv_waddr = x_ff;
            if (left_ff) begin
               pv_wdata = pv_rdata;
               nx_wdata = y_ff;
               tmp_in   = pv_rdata;
            end else begin
               pv_wdata = y_ff;
               nx_wdata = nx_rdata;
               tmp_in   = nx_rdata;
            end
            state_in = S_M4;
         end
         S_M4: begin
            nx_we    = 1'b1;
            pv_we    = 1'b1;
            nx_wdata = x_ff;
            pv_wdata = x_ff;
            if (left_ff) begin
               nx_waddr = tmp_ff;
               pv_waddr = y_ff;
            end else begin
               pv_waddr = tmp_ff;
               nx_waddr = y_ff;
            end
            state_in = S_IDLE;
         end
         S_W0: begin
            rd_addr  = x_ff;
            state_in = S_W1;
         end
         S_W1: begin
            xp_in    = pv_rdata;
            xn_in    = nx_rdata;
            rd_addr  = y_ff;
            state_in = S_W2;
         end
         S_W2: begin
            yp_in    = pv_rdata;
            yn_in    = nx_rdata;
            step_in  = '0;
            state_in = S_W3;
         end
         S_W3: begin
            nx_we   = 1'b1;
            pv_we   = 1'b1;
            step_in = step_ff + 2'd1;
            if (xn_ff == y_ff) begin
               unique case (step_ff)
                  2'd0: begin
                     nx_waddr = xp_ff; nx_wdata = y_ff;
                     pv_waddr = yn_ff; pv_wdata = x_ff;
                  end
                  2'd1: begin
                     nx_waddr = y_ff;  nx_wdata = x_ff;
                     pv_waddr = y_ff;  pv_wdata = xp_ff;
                  end
                  default: begin
                     nx_waddr = x_ff;  nx_wdata = yn_ff;
                     pv_waddr = x_ff;  pv_wdata = y_ff;
                  end
               endcase
               if (step_ff == 2'd2) begin
                  state_in = S_IDLE;
               end
            end else if (xp_ff == y_ff) begin
               unique case (step_ff)
                  2'd0: begin
                     nx_waddr = yp_ff; nx_wdata = x_ff;
                     pv_waddr = xn_ff; pv_wdata = y_ff;
                  end
                  2'd1: begin
                     nx_waddr = x_ff;  nx_wdata = y_ff;
                     pv_waddr = x_ff;  pv_wdata = yp_ff;
                  end
                  default: begin
                     nx_waddr = y_ff;  nx_wdata = xn_ff;
                     pv_waddr = y_ff;  pv_wdata = x_ff;
                  end
               endcase
               if (step_ff == 2'd2) begin
                  state_in = S_IDLE;
               end
            end else begin
               unique case (step_ff)
                  2'd0: begin
                     nx_waddr = xp_ff; nx_wdata = y_ff;
                     pv_waddr = xn_ff; pv_wdata = y_ff;
                  end
                  2'd1: begin
                     nx_waddr = y_ff;  nx_wdata = xn_ff;
                     pv_waddr = y_ff;  pv_wdata = xp_ff;
                  end
                  2'd2: begin
                     nx_waddr = yp_ff; nx_wdata = x_ff;
                     pv_waddr = yn_ff; pv_wdata = x_ff;
                  end
                  default: begin
                     nx_waddr = x_ff;  nx_wdata = yn_ff;
                     pv_waddr = x_ff;  pv_wdata = yp_ff;
                  end
               endcase
               if (step_ff == 2'd3) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_R0: begin
            rd_addr  = idx_ff;
            state_in = S_R1;
         end
         S_R1: begin
            rd_addr = nx_rdata;
            if (hops_dec == 2'd0) begin
               sum_in    = sum_ff + SUM_W'(nx_rdata);
               remain_in = remain_ff - AW'(1);
               hops_in   = 2'd2;
               if (remain_ff == AW'(1)) begin
                  state_in = S_OUT;
               end
            end else begin
               hops_in = hops_dec;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = sum_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         box_count_ff <= BOX_W'(1);
         reversed_ff  <= 1'b0;
         linked_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reversed_ff  <= reversed_in;
         linked_ff    <= linked_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            box_count_ff <= csr_chan.payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      y_ff       <= y_in;
      left_ff    <= left_in;
      tmp_ff     <= tmp_in;
      xp_ff      <= xp_in;
      xn_ff      <= xn_in;
      yp_ff      <= yp_in;
      yn_ff      <= yn_in;
      step_ff    <= step_in;
      idx_ff     <= idx_in;
      remain_ff  <= remain_in;
      hops_ff    <= hops_in;
      sum_ff     <= sum_in;
      rsp_sum_ff <= rsp_sum_in;
   end
endmodule
